// File: rtl/upd_pkg.sv
// Shared types, constants and helpers for the URL percent decoder.
// No dependencies; used by all rtl/upd_* modules and the top level.
`default_nettype none

package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         MAX_OUT    = 3;

    // number of bytes held back by the front end
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // one queue entry: up to three output bytes from one input word
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              cnt;   // 1..3 valid bytes, lowest index first
        logic                    last;  // final byte of entry ends the string
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        return r;
    endfunction

    // digits keep their low nibble, letters (either case) add 9
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = c[6] ? (c[3:0] + 4'd9) : c[3:0];
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/upd_front.sv
// Front end: accepts raw bytes, tracks held '%' and first digit, and
// builds at most one queue entry per word. Depends on upd_pkg.
`default_nettype none

module upd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire upd_pkg::q_status_t q_status,
    output logic               push,
    output upd_pkg::cmd_t      push_cmd
);

    logic [1:0] pend_reg, pend_next;
    logic [7:0] digit_reg, digit_next;

    logic [1:0] n;
    logic       fresh;
    logic [7:0] decoded;

    assign in_ready = !q_status.full;
    assign decoded  = {upd_pkg::hex_val(digit_reg), upd_pkg::hex_val(in_byte)};

    always_comb begin
        n          = 2'd0;
        fresh      = 1'b0;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        push_cmd   = '0;
        case (pend_reg)
            upd_pkg::PEND_PCT: begin
                if (upd_pkg::is_hex(in_byte)) begin
                    digit_next = in_byte;
                    pend_next  = upd_pkg::PEND_DIGIT;
                end else begin
                    push_cmd.bytes[0] = upd_pkg::PCT_CHAR;
                    n     = 2'd1;
                    fresh = 1'b1;
                end
            end
            upd_pkg::PEND_DIGIT: begin
                if (upd_pkg::is_hex(in_byte) &&
                    !(digit_reg == upd_pkg::ZERO_CHAR && in_byte == upd_pkg::ZERO_CHAR)) begin
                    push_cmd.bytes[0] = decoded;
                    n         = 2'd1;
                    pend_next = upd_pkg::PEND_NONE;
                end else begin
                    push_cmd.bytes[0] = upd_pkg::PCT_CHAR;
                    push_cmd.bytes[1] = digit_reg;
                    n     = 2'd2;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        if (fresh) begin
            if (in_byte == upd_pkg::PCT_CHAR) begin
                pend_next = upd_pkg::PEND_PCT;
            end else begin
                push_cmd.bytes[n] = in_byte;
                n         = n + 2'd1;
                pend_next = upd_pkg::PEND_NONE;
            end
        end

        // end of string: flush held bytes behind this word's output
        if (in_last) begin
            if (pend_next != upd_pkg::PEND_NONE) begin
                push_cmd.bytes[n] = upd_pkg::PCT_CHAR;
                n = n + 2'd1;
            end
            if (pend_next == upd_pkg::PEND_DIGIT) begin
                push_cmd.bytes[n] = digit_next;
                n = n + 2'd1;
            end
            pend_next = upd_pkg::PEND_NONE;
        end

        push_cmd.cnt  = n;
        push_cmd.last = in_last;
    end

    assign push = in_valid && in_ready && (n != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= upd_pkg::PEND_NONE;
        end else if (in_valid && in_ready) begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/upd_queue.sv
// Small FIFO of decode entries between front and back end.
// Depends on upd_pkg for the entry and status types.
`default_nettype none

module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire upd_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output upd_pkg::cmd_t      head,
    output upd_pkg::q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == FULL_CNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/upd_back.sv
// Back end: walks the bytes of the head queue entry, one per cycle while
// the output is not stalled, into the output register. Depends on upd_pkg.
`default_nettype none

module upd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire upd_pkg::cmd_t head,
    input  wire upd_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       emit;
    logic       at_end;

    assign emit   = !q_status.empty && (!valid_reg || out_ready);
    assign at_end = (idx_reg == head.cnt - 2'd1);
    assign pop    = emit && at_end;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Instantiates upd_front, upd_queue and upd_back; uses upd_pkg.
`default_nettype none

// Streaming URL percent decoder. Raw string bytes come in one per word on
// the s_axis side, tlast on the final byte; decoded bytes leave on m_axis,
// tlast on the final decoded byte. "%XY" with two hex digits (either case)
// becomes the byte 0xXY, except "%00" which passes through as three bytes.
// A broken sequence emits its '%' (and held digit) literally and the
// offending byte is looked at again, so it may open a new sequence. Up to
// two bytes ('%' and one digit) are held back and flushed on tlast.
// Timing: an input word is taken every cycle while the entry queue
// (QUEUE_DEPTH entries) has room. The front end turns each word into 0..3
// output bytes in the same cycle; the back end drains one byte per cycle,
// while m_axis is not stalled, into a registered m_axis stage; a word
// that yields two or three bytes (broken sequence, end of string) sends
// them one at a time. Each entry is written into the queue, and its bytes
// then leave through the output register. No clearing pass after reset.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // out_last
);

    upd_pkg::q_status_t q_status;
    upd_pkg::cmd_t      push_cmd;
    upd_pkg::cmd_t      head;
    logic               push;
    logic               pop;

    // classify and collapse percent sequences
    upd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples input acceptance from output back-pressure
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // serialize entries to one byte per word
    upd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: sim/tb_url_percent_decoder.sv
// Self-checking testbench for url_percent_decoder: stream-bus stimulus, a
// behavioral percent-decode predictor and an in-order scoreboard.
// Depends on rtl/upd_pkg.sv and rtl/url_percent_decoder.sv.
`timescale 1ns / 100ps

module tb_url_percent_decoder;

    localparam int unsigned LONG_HOLD      = 64;   // output held off, in cycles
    localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no word moving
    localparam int unsigned PHASE_WORDS    = 76;   // random words per idle mix
    localparam int unsigned DRAIN_CYCLES   = 20;   // settle time after last word

    // one decoded word as it should leave on m_axis
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } dec_word_t;

    // directed row: input word, plus hand-written results where typed is set
    // (d0 first out, dlast = tlast on the final result of the row)
    typedef struct packed {
        logic [7:0] raw;
        logic       fin;
        logic       typed;
        logic [1:0] n;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       dlast;
    } dir_row_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;   // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // out_last

    url_percent_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    // Directed strings. Rows without typed results go through the predictor.
    dir_row_t dir_rows [0:24] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0}, // NUL is plain data
        '{8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%41" -> 'A'
        '{8'h34, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h31, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%fF" -> 0xFF
        '{8'h66, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h46, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%00" stays literal
        '{8'h30, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h30, 1'b0, 1'b1, 2'd3, 8'h25, 8'h30, 8'h30, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%g" broken early
        '{8'h67, 1'b0, 1'b1, 2'd2, 8'h25, 8'h67, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%a%09": '%' reopens
        '{8'h61, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h30, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h39, 1'b0, 1'b1, 2'd1, 8'h09, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%%B" + tlast flush
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h42, 1'b1, 1'b1, 2'd2, 8'h25, 8'h42, 8'h00, 1'b1},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}, // "%1%" ends: 3 out
        '{8'h31, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h25, 1'b1, 1'b1, 2'd3, 8'h25, 8'h31, 8'h25, 1'b1},
        '{8'h78, 1'b1, 1'b1, 2'd1, 8'h78, 8'h00, 8'h00, 1'b1}  // one-byte string
    };

    // Predictor state: bytes held back while a sequence is open.
    logic [1:0] held_cnt   = upd_pkg::PEND_NONE;
    logic [7:0] held_pct   = 8'h00;
    logic [7:0] held_digit = 8'h00;
    logic [7:0] step_bytes [0:2];
    int         step_n;

    dec_word_t   decoded_q [$];   // decoded words still owed by the block
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned err_count     = 0;
    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned strings_sent  = 0;
    int unsigned idle_cycles   = 0;

    // long output hold: main flips hold_kick, the receiver loads its own count
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    function automatic logic hex_char(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]})
            t = c - 8'd48;
        else if (c inside {[8'h41:8'h46]})
            t = c - 8'd55;
        else if (c inside {[8'h61:8'h66]})
            t = c - 8'd87;
        v = t[3:0];
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [7:0] rand_hex();
        logic [31:0] r;
        r = $urandom;
        if (r[3:0] < 4'd10)
            return 8'h30 + {4'd0, r[3:0]};
        return (r[4] ? 8'h41 : 8'h61) + {4'd0, r[3:0]} - 8'd10;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        step_bytes[step_n] = b;
        step_n++;
    endtask

    // byte looked at with nothing held
    task automatic take_plain(input logic [7:0] b);
        if (b == upd_pkg::PCT_CHAR) begin
            held_pct = b;
            held_cnt = upd_pkg::PEND_PCT;
        end else begin
            held_cnt = upd_pkg::PEND_NONE;
            emit_byte(b);
        end
    endtask

    // advance the decoder state by one accepted word; queue results if keep
    task automatic decode_word(input logic [7:0] raw, input logic fin, input bit keep);
        logic [3:0] hi_v;
        logic [3:0] lo_v;
        logic       hi_ok;
        logic       lo_ok;
        dec_word_t  w;
        step_n = 0;
        case (held_cnt)
            upd_pkg::PEND_PCT: begin
                if (hex_char(raw, lo_v)) begin
                    held_digit = raw;
                    held_cnt = upd_pkg::PEND_DIGIT;
                end else begin
                    emit_byte(held_pct);
                    held_cnt = upd_pkg::PEND_NONE;
                    take_plain(raw);
                end
            end
            upd_pkg::PEND_DIGIT: begin
                hi_ok = hex_char(held_digit, hi_v);
                lo_ok = hex_char(raw, lo_v);
                if (hi_ok && lo_ok && !(held_digit == upd_pkg::ZERO_CHAR &&
                                        raw == upd_pkg::ZERO_CHAR)) begin
                    emit_byte({hi_v, lo_v});
                    held_cnt = upd_pkg::PEND_NONE;
                end else begin
                    emit_byte(held_pct);
                    emit_byte(held_digit);
                    held_cnt = upd_pkg::PEND_NONE;
                    take_plain(raw);
                end
            end
            default: begin
                take_plain(raw);
            end
        endcase
        if (fin) begin
            if (held_cnt == upd_pkg::PEND_PCT || held_cnt == upd_pkg::PEND_DIGIT)
                emit_byte(held_pct);
            if (held_cnt == upd_pkg::PEND_DIGIT) emit_byte(held_digit);
            held_cnt = upd_pkg::PEND_NONE;
        end
        if (keep) begin
            for (int i = 0; i < step_n; i++) begin
                w.data = step_bytes[i];
                w.fin  = fin && (i == step_n - 1);
                decoded_q.push_back(w);
            end
        end
    endtask

    // Offer one word from a falling edge, with random idle cycles first;
    // returns at the rising edge where it is taken.
    task automatic send_word(input logic [7:0] raw, input logic fin, input bit keep);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tlast  <= fin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_in++;
        decode_word(raw, fin, keep);
    endtask

    // Random string built mostly from escapes; cut at a random length so
    // strings also end inside an open sequence.
    task automatic send_string(input int unsigned len);
        logic [7:0]  bytes [$];
        logic [31:0] r;
        int unsigned kind;
        while (bytes.size() < len) begin
            kind = $urandom_range(99);
            r = $urandom;
            if (kind < 40) begin
                bytes.push_back(upd_pkg::PCT_CHAR);
                if (r[3:0] == 4'd0) begin
                    bytes.push_back(upd_pkg::ZERO_CHAR);
                    bytes.push_back(upd_pkg::ZERO_CHAR);
                end else begin
                    bytes.push_back(rand_hex());
                    bytes.push_back(rand_hex());
                end
            end else if (kind < 50) begin
                bytes.push_back(upd_pkg::PCT_CHAR);
            end else if (kind < 62) begin
                // second digit replaced by an arbitrary byte
                bytes.push_back(upd_pkg::PCT_CHAR);
                bytes.push_back(rand_hex());
                bytes.push_back(r[15:8]);
            end else begin
                bytes.push_back(r[7:0]);
            end
        end
        for (int i = 0; i < len; i++)
            send_word(bytes[i], i == len - 1, 1'b1);
        strings_sent++;
    endtask

    task automatic wait_drained();
        while (decoded_q.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stalls, or a long hold counted here once kicked.
    always @(negedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen     <= hold_kick;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Scoreboard: every output word against the oldest expectation.
    always @(posedge aclk) begin
        dec_word_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (decoded_q.size() == 0) begin
                $error("unexpected output word: out_byte 0x%02h out_last %0b",
                       m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                exp_w = decoded_q.pop_front();
                if (m_axis_tdata !== exp_w.data) begin
                    $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                           exp_w.data, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== exp_w.fin) begin
                    $error("out_last mismatch: expected %0b, actual %0b",
                           exp_w.fin, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves a word.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_url_percent_decoder failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned phase_start;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings, no idling
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].raw, dir_rows[i].fin, !dir_rows[i].typed);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].n >= 2'd1)
                    decoded_q.push_back('{dir_rows[i].d0,
                                          dir_rows[i].dlast && dir_rows[i].n == 2'd1});
                if (dir_rows[i].n >= 2'd2)
                    decoded_q.push_back('{dir_rows[i].d1,
                                          dir_rows[i].dlast && dir_rows[i].n == 2'd2});
                if (dir_rows[i].n == 2'd3)
                    decoded_q.push_back('{dir_rows[i].d2, dir_rows[i].dlast});
            end
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // random strings under four flow-control mixes; the first mix also
        // holds the output off long enough for the input to back up
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            if (phase == 0) hold_kick <= ~hold_kick;
            phase_start = words_in;
            while (words_in - phase_start < PHASE_WORDS)
                send_string($urandom_range(1, 12));
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            // sender waits here for every owed word
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("covered %0d input words in %0d strings, %0d decoded words checked",
                 words_in, strings_sent + 3, words_out);
        $display("flow mixes: free-running, sender gaps, receiver stalls, both, long hold");
        if (err_count == 0 && decoded_q.size() == 0) begin
            $display("tb_url_percent_decoder passed");
        end else begin
            $display("tb_url_percent_decoder failed");
        end
        $finish;
    end

endmodule

// File: url_percent_decoder.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
sim/tb_url_percent_decoder.sv
